// ===== rtl/hbdc_pkg.sv =====
// ----------------------------------------------------------------------------
// hbdc_pkg: shared constants and helpers for the half-bridge compare unit
// Register indexes, reset values, duty scale, reciprocal and clamp functions.
// ----------------------------------------------------------------------------
package hbdc_pkg;

    // register indexes of the write port
    typedef enum logic [2:0] {
        REG_PERIOD   = 3'd0,
        REG_DEADTIME = 3'd1,
        REG_FLOOR    = 3'd2,
        REG_CEILING  = 3'd3,
        REG_READY    = 3'd4
    } t_reg_idx;

    localparam int unsigned CFG_ADDR_W  = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned PERIOD_W    = 16;
    localparam int unsigned DEAD_W      = 14;
    localparam int unsigned DUTY_W      = 14;
    localparam int unsigned IN_DUTY_W   = 16;
    localparam int unsigned CMP_W       = 16;
    localparam int unsigned PROD_W      = PERIOD_W + DUTY_W;   // period * duty
    localparam int unsigned QUOT_W      = 17;                  // < 2^30 / 10000

    // reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RST   = 16'd65280;
    localparam logic [DEAD_W-1:0]   DEADTIME_RST = 14'd3;
    localparam logic [DUTY_W-1:0]   FLOOR_RST    = 14'd0;
    localparam logic [DUTY_W-1:0]   CEILING_RST  = 14'd10000;

    // duty full scale, 0.01 percent units
    localparam logic [IN_DUTY_W-1:0] DUTY_FULL = 16'd10000;

    // x / 10000 = (x * RECIP_MULT) >> RECIP_SHIFT, exact for x < 2^30
    localparam int unsigned RECIP_W     = 30;
    localparam int unsigned RECIP_SHIFT = 43;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 30'd879609303;

    localparam int unsigned GUARD_TICKS_DEF = 3;

    // clamp a 16-bit duty into [lo, hi]; low bound is tested first
    function automatic logic [DUTY_W-1:0] f_clamp_duty(
        input logic [IN_DUTY_W-1:0] v,
        input logic [DUTY_W-1:0]    lo,
        input logic [DUTY_W-1:0]    hi
    );
        logic [DUTY_W-1:0] res;
        if (v < {2'b00, lo}) begin
            res = lo;
        end else if (v > {2'b00, hi}) begin
            res = hi;
        end else begin
            res = v[DUTY_W-1:0];
        end
        return res;
    endfunction

    // low-side set compare: high + dead, kept in [min(high+g, ug), ug]
    function automatic logic [CMP_W-1:0] f_low_set(
        input logic [CMP_W-1:0]  high,
        input logic [DEAD_W-1:0] dead,
        input logic [CMP_W-1:0]  ug,
        input logic [CMP_W-1:0]  g
    );
        logic [CMP_W:0]   sum;
        logic [CMP_W:0]   lo_ext;
        logic [CMP_W-1:0] lo;
        logic [CMP_W-1:0] res;
        sum    = {1'b0, high} + {3'b000, dead};
        lo_ext = {1'b0, high} + {1'b0, g};
        lo     = (lo_ext > {1'b0, ug}) ? ug : lo_ext[CMP_W-1:0];
        if (sum < {1'b0, lo}) begin
            res = lo;
        end else if (sum > {1'b0, ug}) begin
            res = ug;
        end else begin
            res = sum[CMP_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/half_bridge_duty_to_compare_unit.sv =====
// ----------------------------------------------------------------------------
// half_bridge_duty_to_compare_unit: duty to timer compare converter
// Maps buck and boost duties to dead-time guarded compares for two bridges.
// ----------------------------------------------------------------------------
// Takes one request per clock unless a result-side stall has filled every
// stage, through five register stages: duty clamp, period multiply, divide
// by 10000 through a reciprocal multiply, window clamp, low-side compare.
// The reciprocal multiply (30 x 30 bits) sets the stage depth.
// A stall on the master side holds only occupied stages, so bubbles are
// squeezed out before the input is held off.
// A request with lockout set, or sent before ready_cfg is written to 1,
// returns applied = 0 and all compares 0. Configuration is written through
// i_cfg_we / i_cfg_addr / i_cfg_wdata; the derived windows settle through
// chained registers, so write registers only while no request is in flight.
module half_bridge_duty_to_compare_unit #(
    parameter int unsigned GUARD_TICKS = hbdc_pkg::GUARD_TICKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // request side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // buck_duty[15:0], boost_low_duty[31:16]
    input  logic        s_axis_tuser,   // lockout[0]
    // result side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // high_on_compare[15:0],
                                        // buck_high_off_compare[31:16],
                                        // buck_low_on_compare[47:32],
                                        // boost_high_off_compare[63:48],
                                        // boost_low_on_compare[79:64]
    output logic        m_axis_tuser    // applied[0]
);

    localparam int unsigned NSTG = 5;
    localparam logic [15:0] G16  = 16'(GUARD_TICKS);
    localparam logic [15:0] G2   = 16'(2 * GUARD_TICKS);

    // configuration registers
    logic [15:0] r_period;
    logic [13:0] r_dead;
    logic [13:0] r_floor;
    logic [13:0] r_ceil;
    logic        r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= hbdc_pkg::PERIOD_RST;
            r_dead   <= hbdc_pkg::DEADTIME_RST;
            r_floor  <= hbdc_pkg::FLOOR_RST;
            r_ceil   <= hbdc_pkg::CEILING_RST;
            r_ready  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                hbdc_pkg::REG_PERIOD:   r_period <= i_cfg_wdata;
                hbdc_pkg::REG_DEADTIME: r_dead   <= i_cfg_wdata[13:0];
                hbdc_pkg::REG_FLOOR:    r_floor  <= i_cfg_wdata[13:0];
                hbdc_pkg::REG_CEILING:  r_ceil   <= i_cfg_wdata[13:0];
                hbdc_pkg::REG_READY:    r_ready  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // derived guard windows, settled in three steps after a write
    logic [15:0] r_lead;       // leading high-side set compare
    logic [15:0] r_ugrd;       // upper guard limit
    logic [15:0] r_pmt;        // period minus trailing window
    logic        r_pmt_ok;     // period above trailing window
    logic [15:0] r_wlo;        // window low
    logic [15:0] r_whi;        // window high
    logic [15:0] n_lead;
    logic [15:0] n_wlo;
    logic [15:0] n_whi;
    logic [16:0] lead_g;
    logic [15:0] pmg;
    logic [15:0] dead16;
    logic [15:0] trail;

    always_comb begin
        dead16 = {2'b00, r_dead};
        trail  = dead16 + G16;
        pmg    = r_period - G16;
        if (r_period <= G2) begin
            n_lead = G16;
        end else if (dead16 < G16) begin
            n_lead = G16;
        end else if (dead16 > pmg) begin
            n_lead = pmg;
        end else begin
            n_lead = dead16;
        end
        lead_g = {1'b0, r_lead} + {1'b0, G16};
        if (lead_g < {1'b0, G16}) begin
            n_wlo = G16;
        end else if (lead_g > {1'b0, r_ugrd}) begin
            n_wlo = r_ugrd;
        end else begin
            n_wlo = lead_g[15:0];
        end
        if (!r_pmt_ok || r_pmt < r_wlo) begin
            n_whi = r_wlo;
        end else begin
            n_whi = r_pmt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lead   <= n_lead;
        r_ugrd   <= (r_period > G16) ? pmg : G16;
        r_pmt_ok <= r_period > trail;
        r_pmt    <= r_period - trail;
        r_wlo    <= n_wlo;
        r_whi    <= n_whi;
    end

    // per-stage advance: a stage moves when empty or when the next one moves
    logic [NSTG:1] r_vld;
    logic [NSTG+1:1] en;

    always_comb begin
        en[NSTG+1] = m_axis_tready;
        for (int k = NSTG; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) r_vld[1] <= s_axis_tvalid;
            for (int k = 2; k <= NSTG; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // stage 1: duty clamp and boost complement
    logic [13:0] r1_buck;
    logic [13:0] r1_boost;
    logic        r1_blk;
    logic [15:0] bl_in;
    logic [15:0] bl_cmp;
    logic [13:0] n1_bpre;
    logic [13:0] n1_boost;
    logic [13:0] n1_buck;

    always_comb begin
        bl_in  = s_axis_tdata[31:16];
        bl_cmp = hbdc_pkg::DUTY_FULL - bl_in;
        if (bl_in >= hbdc_pkg::DUTY_FULL) begin
            n1_bpre = r_floor;
        end else begin
            n1_bpre = hbdc_pkg::f_clamp_duty({2'b00, bl_cmp[13:0]}, r_floor, r_ceil);
        end
        // scaling clamps once more; this swaps the bounds when floor > ceiling
        n1_boost = hbdc_pkg::f_clamp_duty({2'b00, n1_bpre}, r_floor, r_ceil);
        n1_buck  = hbdc_pkg::f_clamp_duty(
            {2'b00, hbdc_pkg::f_clamp_duty(s_axis_tdata[15:0], r_floor, r_ceil)},
            r_floor, r_ceil);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_buck  <= n1_buck;
            r1_boost <= n1_boost;
            r1_blk   <= !r_ready || s_axis_tuser;
        end
    end

    // stage 2: period times duty
    logic [29:0] r2_buck;
    logic [29:0] r2_boost;
    logic        r2_blk;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_buck  <= 30'(r_period * r1_buck);
            r2_boost <= 30'(r_period * r1_boost);
            r2_blk   <= r1_blk;
        end
    end

    // stage 3: divide by full scale through the reciprocal
    logic [16:0] r3_buck;
    logic [16:0] r3_boost;
    logic        r3_blk;
    logic [59:0] q_buck;
    logic [59:0] q_boost;

    always_comb begin
        q_buck  = r2_buck * hbdc_pkg::RECIP_MULT;
        q_boost = r2_boost * hbdc_pkg::RECIP_MULT;
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_buck  <= q_buck[hbdc_pkg::RECIP_SHIFT +: hbdc_pkg::QUOT_W];
            r3_boost <= q_boost[hbdc_pkg::RECIP_SHIFT +: hbdc_pkg::QUOT_W];
            r3_blk   <= r2_blk;
        end
    end

    // stage 4: clamp into the guard window
    logic [15:0] r4_buck;
    logic [15:0] r4_boost;
    logic        r4_blk;
    logic [15:0] n4_buck;
    logic [15:0] n4_boost;

    always_comb begin
        if (r3_buck < {1'b0, r_wlo}) begin
            n4_buck = r_wlo;
        end else if (r3_buck > {1'b0, r_whi}) begin
            n4_buck = r_whi;
        end else begin
            n4_buck = r3_buck[15:0];
        end
        if (r3_boost < {1'b0, r_wlo}) begin
            n4_boost = r_wlo;
        end else if (r3_boost > {1'b0, r_whi}) begin
            n4_boost = r_whi;
        end else begin
            n4_boost = r3_boost[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_buck  <= n4_buck;
            r4_boost <= n4_boost;
            r4_blk   <= r3_blk;
        end
    end

    // stage 5: low-side compares and output register
    logic [79:0] r5_data;
    logic        r5_applied;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_applied <= !r4_blk;
            if (r4_blk) begin
                r5_data <= '0;
            end else begin
                r5_data <= {hbdc_pkg::f_low_set(r4_boost, r_dead, r_ugrd, G16),
                            r4_boost,
                            hbdc_pkg::f_low_set(r4_buck, r_dead, r_ugrd, G16),
                            r4_buck,
                            r_lead};
            end
        end
    end

    assign m_axis_tvalid = r_vld[NSTG];
    assign m_axis_tdata  = r5_data;
    assign m_axis_tuser  = r5_applied;

    // a blocked result carries no compares
    a_blocked_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("blocked result with nonzero compares");

    // low-side set never precedes high-side reset
    a_low_after_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[47:32] >= m_axis_tdata[31:16] &&
            m_axis_tdata[79:64] >= m_axis_tdata[63:48])
        else $error("low-side compare before high-side compare");

    // input is held off only when every stage is occupied
    a_full_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> &r_vld)
        else $error("input stalled with a free stage");

endmodule

// ===== sim/tb_half_bridge_duty_to_compare_unit.sv =====
// ----------------------------------------------------------------------------
// tb_half_bridge_duty_to_compare_unit: self-checking bench for the compare unit
// Drives duty requests with random gaps, stalls the result side at random and
// checks every result field against a local model of the duty-to-compare math.
// ----------------------------------------------------------------------------
module tb_half_bridge_duty_to_compare_unit;

    localparam int unsigned GUARD          = 3;
    localparam int unsigned FULL_SCALE     = 10000;
    localparam int unsigned STALL_MAX      = 12;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned DRAIN_CYCLES   = 12;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES    = 80;
    localparam int unsigned RANDOM_PHASES  = 12;
    localparam int unsigned PHASE_REQUESTS = 125;
    localparam int unsigned REPORT_MAX     = 10;

    // one result: applied flag plus the five compares
    typedef struct packed {
        logic        applied;
        logic [15:0] high_on;
        logic [15:0] buck_off;
        logic [15:0] buck_low_on;
        logic [15:0] boost_off;
        logic [15:0] boost_low_on;
    } t_compares;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [15:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // buck_duty[15:0], boost_low_duty[31:16]
    logic        s_axis_tuser;   // lockout[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;   // high_on, buck_high_off, buck_low_on,
                                 // boost_high_off, boost_low_on (16 bits each)
    logic        m_axis_tuser;   // applied[0]

    // register shadow used by the compare model
    logic [15:0] cfg_period  = hbdc_pkg::PERIOD_RST;
    logic [13:0] cfg_dead    = hbdc_pkg::DEADTIME_RST;
    logic [13:0] cfg_floor   = hbdc_pkg::FLOOR_RST;
    logic [13:0] cfg_ceiling = hbdc_pkg::CEILING_RST;
    logic        cfg_ready   = 1'b0;

    t_compares   expected_compares[$];
    int unsigned n_sent;
    int unsigned n_checked;
    int unsigned n_applied;
    int unsigned n_mismatch;
    int unsigned n_settings;
    int unsigned hold_cycles;
    bit          tx_idle;
    bit          rx_idle;

    half_bridge_duty_to_compare_unit #(
        .GUARD_TICKS(GUARD)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // compare model
    // ------------------------------------------------------------------------
    function automatic int unsigned clamp_ticks(input int unsigned v,
                                                input int unsigned lo,
                                                input int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // duty -> compare, clamped into the guard window
    function automatic int unsigned scale_duty(input int unsigned duty,
                                               input int unsigned win_lo,
                                               input int unsigned win_hi);
        int unsigned d;
        int unsigned per;
        d   = clamp_ticks(duty, cfg_floor, cfg_ceiling);
        per = cfg_period;
        return clamp_ticks((per * d) / FULL_SCALE, win_lo, win_hi);
    endfunction

    // low side follows high by the dead time, inside the guard limits
    function automatic int unsigned low_side_on(input int unsigned high,
                                                input int unsigned upper);
        int unsigned lo;
        lo = high + GUARD;
        if (lo > upper) lo = upper;
        return clamp_ticks(high + cfg_dead, lo, upper);
    endfunction

    function automatic t_compares predict_compares(input logic [15:0] buck,
                                                   input logic [15:0] boost_low,
                                                   input logic        lockout);
        t_compares   r;
        int unsigned per;
        int unsigned dead;
        int unsigned upper;
        int unsigned lead;
        int unsigned win_lo;
        int unsigned win_hi;
        int unsigned buck_duty;
        int unsigned boost_duty;
        int unsigned buck_cmp;
        int unsigned boost_cmp;
        r = '0;
        if (!cfg_ready || lockout) return r;
        per   = cfg_period;
        dead  = cfg_dead;
        upper = (per > GUARD) ? per - GUARD : GUARD;
        lead  = (per <= 2 * GUARD) ? GUARD : clamp_ticks(dead, GUARD, per - GUARD);
        win_lo = clamp_ticks(lead + GUARD, GUARD, upper);
        // trailing window collapses onto the leading one when too narrow
        if (per <= dead + GUARD) begin
            win_hi = win_lo;
        end else begin
            win_hi = (per - dead - GUARD < win_lo) ? win_lo : per - dead - GUARD;
        end
        buck_duty = clamp_ticks(buck, cfg_floor, cfg_ceiling);
        // boost low-side duty at or past full scale maps to the floor
        if (boost_low >= FULL_SCALE) begin
            boost_duty = cfg_floor;
        end else begin
            boost_duty = clamp_ticks(FULL_SCALE - boost_low, cfg_floor, cfg_ceiling);
        end
        buck_cmp  = scale_duty(buck_duty, win_lo, win_hi);
        boost_cmp = scale_duty(boost_duty, win_lo, win_hi);
        r.applied      = 1'b1;
        r.high_on      = 16'(lead);
        r.buck_off     = 16'(buck_cmp);
        r.buck_low_on  = 16'(low_side_on(buck_cmp, upper));
        r.boost_off    = 16'(boost_cmp);
        r.boost_low_on = 16'(low_side_on(boost_cmp, upper));
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [15:0] buck, input logic [15:0] boost_low,
                                input logic lockout);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, STALL_MAX) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {boost_low, buck};
        s_axis_tuser  <= lockout;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        expected_compares.push_back(predict_compares(buck, boost_low, lockout));
        n_sent++;
    endtask

    function automatic logic [15:0] pick_duty();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(FULL_SCALE - 10, FULL_SCALE + 10));
            default: return 16'($urandom_range(0, FULL_SCALE));
        endcase
    endfunction

    task automatic send_random_request();
        logic [15:0] buck;
        logic [15:0] boost_low;
        buck      = pick_duty();
        boost_low = pick_duty();
        send_request(buck, boost_low, $urandom_range(0, 7) == 0);
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_compares.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write all five registers back to back while the block is idle
    task automatic apply_config(input logic [15:0] period_w, input logic [15:0] dead_w,
                                input logic [15:0] floor_w, input logic [15:0] ceiling_w,
                                input logic [15:0] ready_w);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= hbdc_pkg::REG_PERIOD;
        i_cfg_wdata <= period_w;
        @(posedge i_clk);
        i_cfg_addr  <= hbdc_pkg::REG_DEADTIME;
        i_cfg_wdata <= dead_w;
        @(posedge i_clk);
        i_cfg_addr  <= hbdc_pkg::REG_FLOOR;
        i_cfg_wdata <= floor_w;
        @(posedge i_clk);
        i_cfg_addr  <= hbdc_pkg::REG_CEILING;
        i_cfg_wdata <= ceiling_w;
        @(posedge i_clk);
        i_cfg_addr  <= hbdc_pkg::REG_READY;
        i_cfg_wdata <= ready_w;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_period  = period_w;
        cfg_dead    = dead_w[13:0];
        cfg_floor   = floor_w[13:0];
        cfg_ceiling = ceiling_w[13:0];
        cfg_ready   = ready_w[0];
        n_settings++;
        // let the derived windows settle before the next request
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls, optional long hold-off, field checks
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned seq,
                               input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            n_mismatch++;
            if (n_mismatch <= REPORT_MAX)
                $display("mismatch on result %0d, %s: expected %0d, got %0d",
                         seq, name, want, got);
        end
    endtask

    initial begin : result_checker
        t_compares   got;
        t_compares   want;
        int unsigned stall;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_cycles != 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            stall = rx_idle ? $urandom_range(0, STALL_MAX) : 0;
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            got.applied      = m_axis_tuser;
            got.high_on      = m_axis_tdata[15:0];
            got.buck_off     = m_axis_tdata[31:16];
            got.buck_low_on  = m_axis_tdata[47:32];
            got.boost_off    = m_axis_tdata[63:48];
            got.boost_low_on = m_axis_tdata[79:64];
            if (expected_compares.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= REPORT_MAX)
                    $display("result %0d arrived with no request outstanding", n_checked);
            end else begin
                want = expected_compares.pop_front();
                check_field("applied", n_checked, {15'd0, want.applied},
                            {15'd0, got.applied});
                check_field("high_on_compare", n_checked, want.high_on, got.high_on);
                check_field("buck_high_off_compare", n_checked, want.buck_off,
                            got.buck_off);
                check_field("buck_low_on_compare", n_checked, want.buck_low_on,
                            got.buck_low_on);
                check_field("boost_high_off_compare", n_checked, want.boost_off,
                            got.boost_off);
                check_field("boost_low_on_compare", n_checked, want.boost_low_on,
                            got.boost_low_on);
                if (want.applied) n_applied++;
            end
            n_checked++;
        end
    end

    // watchdog: too long without any handshake on either side
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
                (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_half_bridge_duty_to_compare_unit: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // ready_cfg is clear after reset, so every request comes back blocked
    task automatic test_blocked_until_ready();
        send_request(16'd1234, 16'd5000, 1'b0);
        send_request(16'hFFFF, 16'h0000, 1'b1);
    endtask

    task automatic test_duty_extremes();
        apply_config(16'd10000, 16'd50, 16'd0, 16'd10000, 16'd1);
        send_request(16'd0, 16'd0, 1'b0);
        send_request(16'hFFFF, 16'hFFFF, 1'b0);
        send_request(16'd10000, 16'd10000, 1'b0);
        send_request(16'd9999, 16'd9999, 1'b0);
        send_request(16'd10001, 16'd1, 1'b0);
        send_request(16'd5000, 16'd5000, 1'b0);
        send_request(16'hAAAA, 16'h5555, 1'b0);
        send_request(16'hFFFF, 16'h0000, 1'b1);
    endtask

    // floor is tested first when it sits above the ceiling
    task automatic test_floor_over_ceiling();
        apply_config(16'd20000, 16'd100, 16'd6000, 16'd3000, 16'd1);
        send_request(16'd0, 16'd2000, 1'b0);
        send_request(16'd9000, 16'd9500, 1'b0);
        send_request(16'd4500, 16'd10000, 1'b0);
    endtask

    task automatic test_tiny_period();
        apply_config(16'd4, 16'd3, 16'd0, 16'd10000, 16'd1);
        send_request(16'd5000, 16'd5000, 1'b0);
        send_request(16'd10000, 16'd0, 1'b0);
        apply_config(16'd0, 16'd0, 16'd0, 16'd10000, 16'd1);
        send_request(16'd10000, 16'd0, 1'b0);
        // trailing window below the leading one
        apply_config(16'd100, 16'd200, 16'd0, 16'd10000, 16'd1);
        send_request(16'd7000, 16'd3000, 1'b0);
    endtask

    task automatic test_low_side_crowding();
        apply_config(16'd200, 16'd190, 16'd0, 16'd10000, 16'd1);
        send_request(16'd9000, 16'd1000, 1'b0);
        send_request(16'd10000, 16'd9000, 1'b0);
        // every register at its all-ones word
        apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(16'hFFFF, 16'h0000, 1'b0);
    endtask

    // hold the result side off while requests keep coming back to back
    task automatic test_backpressure();
        apply_config(16'd65280, 16'd500, 16'd500, 16'd9500, 16'd1);
        tx_idle     = 1'b0;
        rx_idle     = 1'b0;
        hold_cycles = HOLD_CYCLES;
        repeat (40) send_random_request();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_random_phases();
        logic [15:0] per;
        logic [13:0] dead;
        logic [13:0] dfloor;
        logic [13:0] dceil;
        logic        ready;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0: per = 16'($urandom_range(0, 12));
                1: per = 16'($urandom_range(100, 2000));
                default: per = 16'($urandom_range(100, 65535));
            endcase
            dead   = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, 16383))
                                                 : 14'($urandom_range(3, per / 8 + 3));
            dfloor = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, 16383))
                                                 : 14'($urandom_range(0, 4000));
            dceil  = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, 16383))
                                                 : 14'($urandom_range(6000, 10000));
            ready  = 1'b1;
            // fixed settings for the first five phases: reset values, ready clear, corner cases
            case (phase)
                0: begin
                    per = 16'd65280; dead = 14'd3; dfloor = 14'd0; dceil = 14'd10000;
                end
                1: ready = 1'b0;
                2: begin
                    per = 16'd100; dead = 14'd3; dfloor = 14'd0; dceil = 14'd10000;
                end
                3: begin
                    per = 16'd65535; dead = 14'd16320; dfloor = 14'd0; dceil = 14'd10000;
                end
                4: begin
                    dfloor = 14'd10000; dceil = 14'd0;
                end
                default: ;
            endcase
            // upper bits of the narrow registers carry random junk
            apply_config(per, {2'($urandom), dead}, {2'($urandom), dfloor},
                         {2'($urandom), dceil}, {15'($urandom), ready});
            tx_idle = (phase % 3) != 2;
            rx_idle = (phase % 4) != 3;
            repeat (PHASE_REQUESTS) send_random_request();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= hbdc_pkg::REG_PERIOD;
        i_cfg_wdata   <= 16'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 32'd0;
        s_axis_tuser  <= 1'b0;
        n_sent        = 0;
        n_checked     = 0;
        n_applied     = 0;
        n_mismatch    = 0;
        n_settings    = 0;
        hold_cycles   = 0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_blocked_until_ready();
        test_duty_extremes();
        test_floor_over_ceiling();
        test_tiny_period();
        test_low_side_crowding();
        test_backpressure();
        test_random_phases();

        s_axis_tvalid <= 1'b0;
        while (expected_compares.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests through %0d register settings, %0d applied and %0d blocked,",
                 n_sent, n_settings, n_applied, n_checked - n_applied);
        $display("with random input gaps, output stalls and one long output hold-off.");
        if (n_mismatch == 0 && expected_compares.size() == 0) begin
            $display("tb_half_bridge_duty_to_compare_unit: clean");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("tb_half_bridge_duty_to_compare_unit: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hbdc_pkg.sv
rtl/half_bridge_duty_to_compare_unit.sv
sim/tb_half_bridge_duty_to_compare_unit.sv
